/* rtl/core/plid_pkg.sv */
// Shared constants, codes and types of the positional list block.
package plid_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int KIND_W     = 3;
   localparam int POS_W      = 8;
   localparam int STATUS_W   = 2;
   localparam int WORD_W     = 32;
   localparam int MODE_W     = 2;

   localparam logic [KIND_W-1:0] KIND_INS_FRONT = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_INS_BACK  = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_INS_POS   = KIND_W'(2);
   localparam logic [KIND_W-1:0] KIND_DEL_FRONT = KIND_W'(3);
   localparam logic [KIND_W-1:0] KIND_DEL_BACK  = KIND_W'(4);
   localparam logic [KIND_W-1:0] KIND_DEL_POS   = KIND_W'(5);
   localparam logic [KIND_W-1:0] KIND_DUMP      = KIND_W'(6);

   localparam logic [STATUS_W-1:0] STATUS_OK      = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_INVALID = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_FULL    = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = STATUS_W'(3);

   localparam logic [MODE_W-1:0] CELL_HOLD   = MODE_W'(0);
   localparam logic [MODE_W-1:0] CELL_INSERT = MODE_W'(1);
   localparam logic [MODE_W-1:0] CELL_DELETE = MODE_W'(2);
   localparam logic [MODE_W-1:0] CELL_ROTATE = MODE_W'(3);

   typedef logic [DATA_WIDTH-1:0] data_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  slot;
      logic [IDX_W-1:0]  tail;
      data_type          value;
   } cell_cmd_type;

endpackage

/* rtl/core/plid_cell.sv */
// One storage cell of the list chain: holds one word, shifts from a neighbor on command.
module plid_cell (
   input  logic                          clock,
   input  plid_pkg::cell_cmd_type        cmd,
   input  logic [plid_pkg::IDX_W-1:0]    cell_id,
   input  plid_pkg::data_type            left_data,
   input  plid_pkg::data_type            right_data,
   input  plid_pkg::data_type            head_data,
   output plid_pkg::data_type            data
);

   plid_pkg::data_type data_ff;
   plid_pkg::data_type data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.mode)
         plid_pkg::CELL_INSERT: begin
            if (cell_id > cmd.slot) begin
               data_in = left_data;
            end else if (cell_id == cmd.slot) begin
               data_in = cmd.value;
            end
         end
         plid_pkg::CELL_DELETE: begin
            if (cell_id >= cmd.slot) begin
               data_in = right_data;
            end
         end
         plid_pkg::CELL_ROTATE: begin
            if (cell_id < cmd.tail) begin
               data_in = right_data;
            end else if (cell_id == cmd.tail) begin
               data_in = head_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* rtl/core/positional_list_insert_delete.sv */
// Positional list top level: command decode, cell chain, dump sequencer and result register.
//
// Usage: an ordered list of up to 16 signed words held in a chain of cells.
// Request channel (req_valid/req_stall) carries kind, value and position;
// result channel (rsp_valid/rsp_stall) carries status, count, element,
// index and last. A transfer happens on a clock edge with valid high and
// stall low.
// Edits (insert/delete at front, back or position): the cells open or close
// a gap at the edge that takes the request, and one result appears in the
// result register on the next cycle. A new request is taken in the same
// cycle that the previous result is transferred, so edits run at one item
// per cycle when the receiver does not stall.
// A dump streams one result per element, one per cycle while the receiver does
// not stall, by rotating the chain one cell per result; the first result is
// loaded in the cycle after the transfer, and requests are stalled until the
// last element has been loaded.
// Reset (synchronous, active high) empties the list and drops any pending
// result. While rsp_stall is high a pending result holds and req_stall rises.
module positional_list_insert_delete (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [plid_pkg::KIND_W-1:0]      req_kind,
   input  logic signed [plid_pkg::WORD_W-1:0] req_value,
   input  logic [plid_pkg::POS_W-1:0]       req_position,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [plid_pkg::STATUS_W-1:0]    rsp_status,
   output logic [plid_pkg::CNT_W-1:0]       rsp_count,
   output logic signed [plid_pkg::WORD_W-1:0] rsp_element,
   output logic [plid_pkg::CNT_W-1:0]       rsp_index,
   output logic                             rsp_last
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;
   localparam int CMP_W = ((plid_pkg::POS_W > plid_pkg::CNT_W) ?
                           plid_pkg::POS_W : plid_pkg::CNT_W) + 1;
   localparam int EXT_W = plid_pkg::DATA_WIDTH + plid_pkg::WORD_W;

   logic                              state_ff, state_in;
   logic [plid_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [plid_pkg::CNT_W-1:0]        dump_idx_ff, dump_idx_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [plid_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [plid_pkg::CNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic [plid_pkg::WORD_W-1:0]       rsp_element_ff, rsp_element_in;
   logic [plid_pkg::CNT_W-1:0]        rsp_index_ff, rsp_index_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              out_free;
   logic                              req_take;
   logic                              dump_step;
   logic                              dump_last;
   logic [CMP_W-1:0]                  pos_c;
   logic [CMP_W-1:0]                  cnt_c;
   logic                              ins_pos_bad;
   logic                              del_pos_bad;
   logic                              list_full;
   logic                              list_empty;
   logic [plid_pkg::IDX_W-1:0]        pos_slot;
   logic [plid_pkg::IDX_W-1:0]        tail_slot;
   logic [plid_pkg::IDX_W-1:0]        count_slot;
   logic [EXT_W-1:0]                  value_ext;
   logic [EXT_W-1:0]                  head_ext;
   logic [plid_pkg::STATUS_W-1:0]     dec_status;
   logic [plid_pkg::CNT_W-1:0]        dec_count;
   logic                              dec_dump;
   plid_pkg::cell_cmd_type            dec_cmd;
   plid_pkg::cell_cmd_type            cell_cmd;
   plid_pkg::data_type                cell_data [plid_pkg::CAPACITY];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == ST_DUMP) || !out_free;
   assign req_take  = req_valid && !req_stall;
   assign dump_step = (state_ff == ST_DUMP) && out_free;
   assign dump_last = (dump_idx_ff + plid_pkg::CNT_W'(1)) == count_ff;

   assign pos_c       = CMP_W'(req_position);
   assign cnt_c       = CMP_W'(count_ff);
   assign ins_pos_bad = (pos_c == '0) || (pos_c > (cnt_c + CMP_W'(1)));
   assign del_pos_bad = (pos_c == '0) || (pos_c > cnt_c);
   assign list_full   = count_ff >= plid_pkg::CNT_W'(plid_pkg::CAPACITY);
   assign list_empty  = count_ff == '0;
   assign pos_slot    = plid_pkg::IDX_W'(req_position - plid_pkg::POS_W'(1));
   assign tail_slot   = plid_pkg::IDX_W'(count_ff - plid_pkg::CNT_W'(1));
   assign count_slot  = plid_pkg::IDX_W'(count_ff);
   assign value_ext   = {{plid_pkg::DATA_WIDTH{req_value[plid_pkg::WORD_W-1]}}, req_value};
   assign head_ext    = {{plid_pkg::WORD_W{1'b0}}, cell_data[0]};

   // decode one request
   always_comb begin
      dec_status    = plid_pkg::STATUS_OK;
      dec_count     = count_ff;
      dec_dump      = 1'b0;
      dec_cmd.mode  = plid_pkg::CELL_HOLD;
      dec_cmd.slot  = '0;
      dec_cmd.tail  = tail_slot;
      dec_cmd.value = value_ext[plid_pkg::DATA_WIDTH-1:0];
      case (req_kind)
         plid_pkg::KIND_INS_FRONT, plid_pkg::KIND_INS_BACK, plid_pkg::KIND_INS_POS: begin
            if ((req_kind == plid_pkg::KIND_INS_POS) && ins_pos_bad) begin
               dec_status = plid_pkg::STATUS_INVALID;
            end else if (list_full) begin
               dec_status = plid_pkg::STATUS_FULL;
            end else begin
               dec_cmd.mode = plid_pkg::CELL_INSERT;
               dec_count    = count_ff + plid_pkg::CNT_W'(1);
               if (req_kind == plid_pkg::KIND_INS_FRONT) begin
                  dec_cmd.slot = '0;
               end else if (req_kind == plid_pkg::KIND_INS_BACK) begin
                  dec_cmd.slot = count_slot;
               end else begin
                  dec_cmd.slot = pos_slot;
               end
            end
         end
         plid_pkg::KIND_DEL_FRONT, plid_pkg::KIND_DEL_BACK, plid_pkg::KIND_DEL_POS: begin
            if (list_empty) begin
               dec_status = plid_pkg::STATUS_EMPTY;
            end else if ((req_kind == plid_pkg::KIND_DEL_POS) && del_pos_bad) begin
               dec_status = plid_pkg::STATUS_INVALID;
            end else begin
               dec_cmd.mode = plid_pkg::CELL_DELETE;
               dec_count    = count_ff - plid_pkg::CNT_W'(1);
               if (req_kind == plid_pkg::KIND_DEL_FRONT) begin
                  dec_cmd.slot = '0;
               end else if (req_kind == plid_pkg::KIND_DEL_BACK) begin
                  dec_cmd.slot = tail_slot;
               end else begin
                  dec_cmd.slot = pos_slot;
               end
            end
         end
         plid_pkg::KIND_DUMP: begin
            if (list_empty) begin
               dec_status = plid_pkg::STATUS_EMPTY;
            end else begin
               dec_dump = 1'b1;
            end
         end
         default: begin
            dec_status = plid_pkg::STATUS_INVALID;
         end
      endcase
   end

   always_comb begin
      cell_cmd = dec_cmd;
      if (state_ff == ST_DUMP) begin
         cell_cmd.mode = dump_step ? plid_pkg::CELL_ROTATE : plid_pkg::CELL_HOLD;
      end else if (!req_take) begin
         cell_cmd.mode = plid_pkg::CELL_HOLD;
      end
   end

   // sequence edits and dump, load the result register
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      dump_idx_in    = dump_idx_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_element_in = rsp_element_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_last_in    = rsp_last_ff;
      if (dump_step) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = plid_pkg::STATUS_OK;
         rsp_count_in   = count_ff;
         rsp_element_in = head_ext[plid_pkg::WORD_W-1:0];
         rsp_index_in   = dump_idx_ff + plid_pkg::CNT_W'(1);
         rsp_last_in    = dump_last;
         dump_idx_in    = dump_idx_ff + plid_pkg::CNT_W'(1);
         if (dump_last) begin
            state_in = ST_IDLE;
         end
      end else if (req_take) begin
         if (dec_dump) begin
            state_in    = ST_DUMP;
            dump_idx_in = '0;
         end else begin
            count_in       = dec_count;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = dec_status;
            rsp_count_in   = dec_count;
            rsp_element_in = '0;
            rsp_index_in   = '0;
            rsp_last_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_element_ff <= rsp_element_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_last_ff    <= rsp_last_in;
   end

   for (genvar i = 0; i < plid_pkg::CAPACITY; i++) begin : g_cell
      plid_pkg::data_type left_d;
      plid_pkg::data_type right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_inner_l
         assign left_d = cell_data[i-1];
      end
      if (i == plid_pkg::CAPACITY - 1) begin : g_end
         assign right_d = '0;
      end else begin : g_inner_r
         assign right_d = cell_data[i+1];
      end
      plid_cell u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .cell_id    (plid_pkg::IDX_W'(i)),
         .left_data  (left_d),
         .right_data (right_d),
         .head_data  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_index   = rsp_index_ff;
   assign rsp_last    = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= plid_pkg::CNT_W'(plid_pkg::CAPACITY))
      else $error("list count beyond capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |->
         (count_ff == $past(count_ff) + plid_pkg::CNT_W'(1)) ||
         (count_ff == $past(count_ff) - plid_pkg::CNT_W'(1)))
      else $error("list count moved by more than one");

   a_dump_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |=> $stable(count_ff))
      else $error("list count changed during dump");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_index_ff <= rsp_count_ff))
      else $error("dump index beyond count");

endmodule
